// File: design/cmo_pkg.sv
package cmo_pkg;

  // Window and price geometry
  localparam int MAX_WINDOW = 64;
  localparam int PRICE_BITS = 32;
  localparam int LEN_W      = 7;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 2);
  localparam int N_W        = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int DIFF_W     = PRICE_BITS + 1;

  // Scaling: 100 * 2^16 = 25 * 2^18, quotient below 2^23
  localparam int SCALE_MUL   = 25;
  localparam int SCALE_SHIFT = 18;
  localparam int Q_W         = 23;
  localparam int LOW_W       = Q_W - SCALE_SHIFT;
  localparam int MUL_W       = SUM_W + LOW_W;
  localparam int QCNT_W      = $clog2(Q_W);
  localparam int OSC_W       = 24;
  localparam int PERCENT_Q16 = 6553600;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(14);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_DONE
  } cmo_state_t;

endpackage

// File: design/chande_momentum_oscillator.sv
// Chande momentum oscillator, one price sample per input beat.
// Input channel: in_price (unsigned ticks) and in_series_start, under
// in_valid/in_ready. A set series_start clears the series; the first sample
// after reset also opens a series. Every input beat yields one output beat:
// out_oscillator (signed Q.16 percent), out_window_full, out_flat_window.
// cfg_write_en/cfg_window_length set the window (0 acts as 1, above 64 acts
// as 64); write it only while the block is idle.
// The price differences live in a 64-entry ring memory. Each sample writes
// its difference, then the window sums are rebuilt by reading the last n
// entries, one memory read per cycle, where n is the number of differences
// in the window. The result beat is then formed, with a division only when
// the window is full and its sums are not both zero; the 23-bit quotient
// comes from a restoring divider at one bit per cycle. in_ready returns
// high with the result beat, so one item is in work at a time.
// A finished beat sits in the output register; the block takes and works on
// the next input beat meanwhile and waits only if the output is still full
// when that next result is ready.
// Reset (rst_n low, synchronous) clears the series and sets the window to 14.
module chande_momentum_oscillator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write_en,
  input  logic [cmo_pkg::LEN_W-1:0]           cfg_window_length,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cmo_pkg::PRICE_BITS-1:0]      in_price,
  input  logic                                in_series_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cmo_pkg::OSC_W-1:0]    out_oscillator,
  output logic                                out_window_full,
  output logic                                out_flat_window
);

  cmo_pkg::cmo_state_t state_r, state_nxt;

  logic [cmo_pkg::LEN_W-1:0]      win_len_r, win_len_nxt;
  logic [cmo_pkg::PRICE_BITS-1:0] prev_price_r, prev_price_nxt;
  logic [cmo_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [cmo_pkg::PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [cmo_pkg::N_W-1:0]        n_r, n_nxt;
  logic [cmo_pkg::N_W-1:0]        k_r, k_nxt;
  logic [cmo_pkg::PTR_W-1:0]      rd_addr_r, rd_addr_nxt;
  logic                           rd_pend_r, rd_pend_nxt;
  logic                           full_r, full_nxt;
  logic [cmo_pkg::SUM_W-1:0]      up_r, up_nxt;
  logic [cmo_pkg::SUM_W-1:0]      down_r, down_nxt;
  logic [cmo_pkg::SUM_W-1:0]      mag_r, mag_nxt;
  logic [cmo_pkg::SUM_W-1:0]      den_r, den_nxt;
  logic                           neg_r, neg_nxt;
  logic [cmo_pkg::OSC_W-1:0]      res_osc_r, res_osc_nxt;
  logic                           res_flat_r, res_flat_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [cmo_pkg::OSC_W-1:0]      out_osc_r, out_osc_nxt;
  logic                           out_full_r, out_full_nxt;
  logic                           out_flat_r, out_flat_nxt;

  logic                           accept;
  logic [cmo_pkg::CNT_W-1:0]      count_eff;
  logic [cmo_pkg::PRICE_BITS-1:0] prev_eff;
  logic [cmo_pkg::PTR_W-1:0]      ptr_eff;
  logic [cmo_pkg::PTR_W-1:0]      ptr_inc;
  logic [cmo_pkg::CNT_W-1:0]      diffs;
  logic [cmo_pkg::N_W-1:0]        len_eff;
  logic                           falling;
  logic [cmo_pkg::DIFF_W-1:0]     diff_word;

  logic                           wr_en;
  logic                           rd_en;
  logic [cmo_pkg::DIFF_W-1:0]     rd_data;
  logic                           div_start;
  logic                           div_done;
  logic [cmo_pkg::Q_W-1:0]        div_q;

  assign in_ready = (state_r == cmo_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Start of a series clears the history seen by this sample
  assign count_eff = in_series_start ? '0 : count_r;
  assign prev_eff  = in_series_start ? '0 : prev_price_r;
  assign ptr_eff   = in_series_start ? '0 : ptr_r;
  assign ptr_inc   = (ptr_eff == cmo_pkg::PTR_W'(cmo_pkg::MAX_WINDOW - 1)) ? '0
                                                                      : ptr_eff + 1'b1;

  // Difference word: falling flag over the move magnitude
  assign falling   = in_price < prev_eff;
  assign diff_word = {falling, falling ? prev_eff - in_price : in_price - prev_eff};
  assign wr_en     = accept && (count_eff != '0);

  // Clamp the window length
  always_comb begin
    if (win_len_r == '0) begin
      len_eff = cmo_pkg::N_W'(1);
    end else if (32'(win_len_r) > cmo_pkg::MAX_WINDOW) begin
      len_eff = cmo_pkg::N_W'(cmo_pkg::MAX_WINDOW);
    end else begin
      len_eff = cmo_pkg::N_W'(win_len_r);
    end
  end

  always_comb begin
    diffs = ((count_eff < cmo_pkg::CNT_W'(cmo_pkg::MAX_WINDOW + 1)) ? count_eff + 1'b1
                                                                    : count_eff) - 1'b1;
  end

  assign rd_en     = (state_r == cmo_pkg::ST_SUM) && (k_r != n_r);
  assign div_start = (state_r == cmo_pkg::ST_START) && (den_r != '0) && full_r;

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    win_len_nxt    = cfg_write_en ? cfg_window_length : win_len_r;
    prev_price_nxt = prev_price_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    rd_addr_nxt    = rd_addr_r;
    rd_pend_nxt    = 1'b0;
    full_nxt       = full_r;
    up_nxt         = up_r;
    down_nxt       = down_r;
    mag_nxt        = mag_r;
    den_nxt        = den_r;
    neg_nxt        = neg_r;
    res_osc_nxt    = res_osc_r;
    res_flat_nxt   = res_flat_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_osc_nxt    = out_osc_r;
    out_full_nxt   = out_full_r;
    out_flat_nxt   = out_flat_r;

    case (state_r)
      cmo_pkg::ST_IDLE: begin
        // Take a sample, store its difference, set up the window walk
        if (accept) begin
          prev_price_nxt = in_price;
          count_nxt      = diffs + 1'b1;
          ptr_nxt        = (count_eff != '0) ? ptr_inc : ptr_eff;
          if (32'(diffs) < 32'(len_eff)) begin
            n_nxt    = cmo_pkg::N_W'(diffs);
            full_nxt = 1'b0;
          end else begin
            n_nxt    = len_eff;
            full_nxt = 1'b1;
          end
          rd_addr_nxt = (ptr_nxt == '0) ? cmo_pkg::PTR_W'(cmo_pkg::MAX_WINDOW - 1)
                                        : ptr_nxt - 1'b1;
          k_nxt     = '0;
          up_nxt    = '0;
          down_nxt  = '0;
          state_nxt = cmo_pkg::ST_SUM;
        end
      end
      cmo_pkg::ST_SUM: begin
        // Issue one read per cycle, walking back from the newest entry
        if (rd_en) begin
          k_nxt       = k_r + 1'b1;
          rd_addr_nxt = (rd_addr_r == '0) ? cmo_pkg::PTR_W'(cmo_pkg::MAX_WINDOW - 1)
                                          : rd_addr_r - 1'b1;
          rd_pend_nxt = 1'b1;
        end
        // Accumulate returning data
        if (rd_pend_r) begin
          if (rd_data[cmo_pkg::DIFF_W-1]) begin
            down_nxt = down_r + cmo_pkg::SUM_W'(rd_data[cmo_pkg::PRICE_BITS-1:0]);
          end else begin
            up_nxt = up_r + cmo_pkg::SUM_W'(rd_data[cmo_pkg::PRICE_BITS-1:0]);
          end
        end
        if ((k_r == n_r) && !rd_pend_r) begin
          state_nxt = cmo_pkg::ST_PREP;
        end
      end
      cmo_pkg::ST_PREP: begin
        // Form magnitude, sign and denominator
        den_nxt = up_r + down_r;
        if (up_r >= down_r) begin
          mag_nxt = up_r - down_r;
          neg_nxt = 1'b0;
        end else begin
          mag_nxt = down_r - up_r;
          neg_nxt = 1'b1;
        end
        state_nxt = cmo_pkg::ST_START;
      end
      cmo_pkg::ST_START: begin
        res_osc_nxt  = '0;
        res_flat_nxt = full_r && (den_r == '0);
        state_nxt    = div_start ? cmo_pkg::ST_DIV : cmo_pkg::ST_DONE;
      end
      cmo_pkg::ST_DIV: begin
        // Apply the sign to the quotient
        if (div_done) begin
          res_osc_nxt = neg_r ? cmo_pkg::OSC_W'(-{1'b0, div_q})
                              : cmo_pkg::OSC_W'(div_q);
          state_nxt   = cmo_pkg::ST_DONE;
        end
      end
      cmo_pkg::ST_DONE: begin
        // Hand the beat to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_osc_nxt   = res_osc_r;
          out_full_nxt  = full_r;
          out_flat_nxt  = res_flat_r;
          state_nxt     = cmo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cmo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cmo_pkg::ST_IDLE;
      win_len_r    <= cmo_pkg::LEN_RESET;
      prev_price_r <= '0;
      count_r      <= '0;
      ptr_r        <= '0;
      k_r          <= '0;
      n_r          <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      win_len_r    <= win_len_nxt;
      prev_price_r <= prev_price_nxt;
      count_r      <= count_nxt;
      ptr_r        <= ptr_nxt;
      k_r          <= k_nxt;
      n_r          <= n_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    full_r     <= full_nxt;
    up_r       <= up_nxt;
    down_r     <= down_nxt;
    mag_r      <= mag_nxt;
    den_r      <= den_nxt;
    neg_r      <= neg_nxt;
    res_osc_r  <= res_osc_nxt;
    res_flat_r <= res_flat_nxt;
    out_osc_r  <= out_osc_nxt;
    out_full_r <= out_full_nxt;
    out_flat_r <= out_flat_nxt;
  end

  cmo_ring_ram #(
    .DEPTH (cmo_pkg::MAX_WINDOW),
    .WIDTH (cmo_pkg::DIFF_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ptr_eff),
    .wr_data (diff_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  cmo_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .mag      (mag_r),
    .den      (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid       = out_valid_r;
  assign out_oscillator  = out_osc_r;
  assign out_window_full = out_full_r;
  assign out_flat_window = out_flat_r;

`ifndef NO_ASSERTIONS
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cmo_pkg::ST_SUM) |-> (k_r <= n_r)) else $error("window walk overran");

  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> accept) else $error("ring written without an input beat");

  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flat_window) |-> (out_oscillator == '0 && out_window_full))
    else $error("flat window with nonzero oscillator");

  a_not_full_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_window_full) |-> (out_oscillator == '0 && !out_flat_window))
    else $error("result reported before the window filled");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == cmo_pkg::ST_DIV)) else $error("stray divider result");
`endif

endmodule

// File: design/cmo_ring_ram.sv
module cmo_ring_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/cmo_divider.sv
module cmo_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cmo_pkg::SUM_W-1:0]   mag,
  input  logic [cmo_pkg::SUM_W-1:0]   den,
  output logic                        done,
  output logic [cmo_pkg::Q_W-1:0]     quotient
);

  logic [cmo_pkg::MUL_W-1:0]  scaled;
  logic [cmo_pkg::SUM_W:0]    trial;
  logic                       fits;
  logic [cmo_pkg::SUM_W-1:0]  rem_r, rem_nxt;
  logic [cmo_pkg::SUM_W-1:0]  den_r;
  logic [cmo_pkg::Q_W-1:0]    sh_r, sh_nxt;
  logic [cmo_pkg::Q_W-1:0]    q_r, q_nxt;
  logic [cmo_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  // Scale magnitude by 25 with shifts and adds
  assign scaled = (cmo_pkg::MUL_W'(mag) << 4) + (cmo_pkg::MUL_W'(mag) << 3)
                + cmo_pkg::MUL_W'(mag);

  // One restoring step per cycle
  assign trial = {rem_r, sh_r[cmo_pkg::Q_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // Dividend is scaled << 18; its top bits are already below den
      rem_nxt  = scaled[cmo_pkg::MUL_W-1:cmo_pkg::LOW_W];
      sh_nxt   = {scaled[cmo_pkg::LOW_W-1:0], cmo_pkg::SCALE_SHIFT'(0)};
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? cmo_pkg::SUM_W'(trial - {1'b0, den_r})
                     : trial[cmo_pkg::SUM_W-1:0];
      sh_nxt  = {sh_r[cmo_pkg::Q_W-2:0], 1'b0};
      q_nxt   = {q_r[cmo_pkg::Q_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == cmo_pkg::QCNT_W'(cmo_pkg::Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");

  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (32'(q_r) <= cmo_pkg::PERCENT_Q16))
    else $error("quotient above full scale");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < den_r)) else $error("partial remainder not reduced");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic signed [cmo_pkg::OSC_W-1:0] osc;
    logic                             full;
    logic                             flat;
  } momentum_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [cmo_pkg::LEN_W-1:0]        len;
    logic [cmo_pkg::PRICE_BITS-1:0]   price;
    logic                             start;
    logic                             has_exp;
    logic signed [cmo_pkg::OSC_W-1:0] osc;
    logic                             full;
    logic                             flat;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 75;
  localparam logic [cmo_pkg::PRICE_BITS-1:0] PRICE_MAX = '1;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_write_en = 1'b0;
  logic [cmo_pkg::LEN_W-1:0]        cfg_window_length = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [cmo_pkg::PRICE_BITS-1:0]   in_price = '0;
  logic                             in_series_start = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [cmo_pkg::OSC_W-1:0] out_oscillator;
  logic                             out_window_full;
  logic                             out_flat_window;

  chande_momentum_oscillator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_window_length (cfg_window_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_price          (in_price),
    .in_series_start   (in_series_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_oscillator    (out_oscillator),
    .out_window_full   (out_window_full),
    .out_flat_window   (out_flat_window)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the series state
  logic [cmo_pkg::LEN_W-1:0]      window_cfg = cmo_pkg::LEN_RESET;
  logic [cmo_pkg::PRICE_BITS-1:0] last_price = '0;
  int unsigned                    seen_count = 0;
  int unsigned                    diff_ptr = 0;
  logic [cmo_pkg::DIFF_W-1:0]     rise_ring [cmo_pkg::MAX_WINDOW];
  logic [cmo_pkg::DIFF_W-1:0]     fall_ring [cmo_pkg::MAX_WINDOW];

  momentum_t expected_q [$];
  int        errors = 0;
  int        send_idle_pct = 34;
  int        recv_idle_pct = 48;

  // Advance the shadow series by one sample and return its momentum
  function automatic momentum_t step_momentum(
      input logic [cmo_pkg::PRICE_BITS-1:0] price, input logic start);
    int unsigned               len;
    int unsigned               diffs;
    int unsigned               span;
    int unsigned               slot;
    logic [cmo_pkg::SUM_W-1:0] rise_sum;
    logic [cmo_pkg::SUM_W-1:0] fall_sum;
    longint unsigned           den;
    longint unsigned           ratio;
    momentum_t                 res;
    res = '0;
    if (start) begin
      last_price = '0;
      seen_count = 0;
      diff_ptr   = 0;
    end
    len = window_cfg;
    if (len == 0) len = 1;
    if (len > cmo_pkg::MAX_WINDOW) len = cmo_pkg::MAX_WINDOW;

    // Record the move against the previous sample
    if (seen_count > 0) begin
      if (price >= last_price) begin
        rise_ring[diff_ptr] = cmo_pkg::DIFF_W'(price - last_price);
        fall_ring[diff_ptr] = '0;
      end else begin
        rise_ring[diff_ptr] = '0;
        fall_ring[diff_ptr] = cmo_pkg::DIFF_W'(last_price - price);
      end
      diff_ptr = (diff_ptr + 1) % cmo_pkg::MAX_WINDOW;
    end
    last_price = price;
    if (seen_count < cmo_pkg::MAX_WINDOW + 1) seen_count++;

    // Sum the most recent moves over the window
    diffs    = seen_count - 1;
    span     = (diffs < len) ? diffs : len;
    rise_sum = '0;
    fall_sum = '0;
    for (int k = 0; k < span; k++) begin
      slot     = (diff_ptr + cmo_pkg::MAX_WINDOW - 1 - k) % cmo_pkg::MAX_WINDOW;
      rise_sum = rise_sum + rise_ring[slot];
      fall_sum = fall_sum + fall_ring[slot];
    end

    if (diffs >= len) begin
      res.full = 1'b1;
      den = longint'(rise_sum) + longint'(fall_sum);
      if (den == 0) begin
        res.flat = 1'b1;
      end else if (rise_sum >= fall_sum) begin
        ratio   = (longint'(rise_sum - fall_sum) * cmo_pkg::PERCENT_Q16) / den;
        res.osc = cmo_pkg::OSC_W'(ratio);
      end else begin
        ratio   = (longint'(fall_sum - rise_sum) * cmo_pkg::PERCENT_Q16) / den;
        res.osc = -cmo_pkg::OSC_W'(ratio);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  // Check result beats and randomize the receiver's stalls
  always @(posedge clk) begin
    momentum_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, queue depth", 0, 1);
      end else begin
        want = expected_q.pop_front();
        if (out_oscillator !== want.osc)
          report_mismatch("oscillator", want.osc, out_oscillator);
        if (out_window_full !== want.full)
          report_mismatch("window_full", want.full, out_window_full);
        if (out_flat_window !== want.flat)
          report_mismatch("flat_window", want.flat, out_flat_window);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Offer one input beat, idling first at random, and hold it until taken
  task automatic send_beat(input logic [cmo_pkg::PRICE_BITS-1:0] price, input logic start,
                           input logic use_typed, input momentum_t typed_exp);
    momentum_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_price        <= price;
    in_series_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = step_momentum(price, start);
    expected_q.push_back(use_typed ? typed_exp : predicted);
  endtask

  // Drop valid and hold off until every result beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [cmo_pkg::LEN_W-1:0] len);
    drain_results();
    cfg_write_en      <= 1'b1;
    cfg_window_length <= len;
    @(posedge clk);
    window_cfg    = len;
    cfg_write_en <= 1'b0;
  endtask

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ITEM, 7'd0,   32'd100,        1'b0, 1'b1, 24'sd0,         1'b0, 1'b0},
    '{ROW_CFG,  7'd1,   32'd0,          1'b0, 1'b0, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'd100,        1'b0, 1'b1, 24'sd0,         1'b1, 1'b1},
    '{ROW_ITEM, 7'd0,   32'hFFFF_FFFF,  1'b0, 1'b1, 24'sd6553600,   1'b1, 1'b0},
    '{ROW_ITEM, 7'd0,   32'd0,          1'b0, 1'b1, -24'sd6553600,  1'b1, 1'b0},
    '{ROW_ITEM, 7'd0,   32'd0,          1'b1, 1'b1, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'hFFFF_FFFF,  1'b0, 1'b1, 24'sd6553600,   1'b1, 1'b0},
    '{ROW_CFG,  7'd0,   32'd0,          1'b0, 1'b0, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'hFFFF_FFFE,  1'b0, 1'b1, -24'sd6553600,  1'b1, 1'b0},
    '{ROW_CFG,  7'd127, 32'd0,          1'b0, 1'b0, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'd7,          1'b0, 1'b1, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'd0,          1'b1, 1'b1, 24'sd0,         1'b0, 1'b0},
    '{ROW_CFG,  7'd2,   32'd0,          1'b0, 1'b0, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'd10,         1'b0, 1'b1, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'd20,         1'b0, 1'b0, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'd15,         1'b0, 1'b0, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'd15,         1'b0, 1'b0, 24'sd0,         1'b0, 1'b0},
    '{ROW_CFG,  7'd65,  32'd0,          1'b0, 1'b0, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'h5555_5555,  1'b0, 1'b0, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'hAAAA_AAAA,  1'b1, 1'b1, 24'sd0,         1'b0, 1'b0},
    '{ROW_CFG,  7'd64,  32'd0,          1'b0, 1'b0, 24'sd0,         1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'd1,          1'b0, 1'b0, 24'sd0,         1'b0, 1'b0}
  };

  logic [cmo_pkg::LEN_W-1:0] phase_len [PHASES] = '{7'd14, 7'd1, 7'd64, 7'd127,
                                                   7'd0, 7'd65, 7'd2, 7'd0};

  initial begin
    logic [cmo_pkg::PRICE_BITS-1:0] cur_price;
    logic [cmo_pkg::PRICE_BITS-1:0] step_size;
    logic                           start;
    logic [cmo_pkg::LEN_W-1:0]      len;
    int                             r;
    int                             wait_cycles;
    cur_price = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_window(directed_rows[i].len);
      end else begin
        send_beat(directed_rows[i].price, directed_rows[i].start, directed_rows[i].has_exp,
                  '{directed_rows[i].osc, directed_rows[i].full, directed_rows[i].flat});
      end
    end

    // Random price walks, one window setting per phase
    for (int p = 0; p < PHASES; p++) begin
      len = (p == PHASES - 1) ? cmo_pkg::LEN_W'($urandom_range(3, 40)) : phase_len[p];
      write_window(len);
      if (p < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 48;
      end else if (p < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 40) drain_results();
        start = ($urandom_range(0, 99) < 2);
        if (start) cur_price = $urandom;
        r = $urandom_range(0, 99);
        step_size = '0;
        if (r < 45) begin
          step_size = $urandom_range(0, 255);
        end else if (r < 75 && r >= 60) begin
          step_size = $urandom & 32'h000F_FFFF;
        end else if (r >= 75 && r < 90) begin
          cur_price = $urandom;
        end else if (r >= 90) begin
          cur_price = $urandom_range(0, 1) ? PRICE_MAX : '0;
        end
        // Move up or down by the step, clamped at the price range
        if ($urandom_range(0, 1)) begin
          cur_price = (cur_price > PRICE_MAX - step_size) ? PRICE_MAX : cur_price + step_size;
        end else begin
          cur_price = (cur_price < step_size) ? '0 : cur_price - step_size;
        end
        send_beat(cur_price, start, 1'b0, '0);
      end
    end

    // Drain, then let the pipeline settle
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 50000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch("results still pending", 0, expected_q.size());
    if (errors == 0) begin
      $display("[chande_momentum_oscillator] OK");
    end else begin
      $display("[chande_momentum_oscillator] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[chande_momentum_oscillator] ERROR");
    $finish;
  end

endmodule
